// ===== sv/mfs_pkg.sv =====
// mfs_pkg: shared types, register indexes and compare helper for the
// motor fault supervisor. No dependencies.
`default_nettype none
package mfs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPIN_SPEED_LIMIT    = 3'd0,
    REG_SPIN_TICK_LIMIT     = 3'd1,
    REG_TILT_LIMIT          = 3'd2,
    REG_LEVEL_WINDOW        = 3'd3,
    REG_STILL_DELTA         = 3'd4,
    REG_CHECK_INTERVAL      = 3'd5,
    REG_STILL_CHECKS_NEEDED = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [14:0] spin_speed_limit;
    logic [15:0] spin_tick_limit;
    logic [15:0] tilt_limit;
    logic [15:0] level_window;
    logic [15:0] still_delta;
    logic [15:0] check_interval;
    logic [7:0]  still_checks_needed;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] left_pulses;
    logic signed [15:0] right_pulses;
    logic signed [16:0] tilt_angle;
    logic               setpoint_is_zero;
  } item_t;

  typedef struct packed {
    logic clear_position;
    logic tilt_fault;
    logic spin_fault;
  } res_t;

  // true when -lim < v < lim
  function automatic logic within_f(input logic signed [19:0] v,
                                    input logic [16:0] lim);
    logic signed [19:0] l;
    l = signed'({3'b000, lim});
    return (v > -l) && (v < l);
  endfunction

endpackage
`default_nettype wire

// ===== sv/motor_fault_supervisor_top.sv =====
// motor_fault_supervisor_top: input register, supervisor core, result register.
// Path: the accepted input word is held in the input register, then its result
// in the result register.
// Throughput: one word per cycle; the input register drains into the result
// register whenever that is empty or being taken.
// Reset (synchronous, rst_n low): valids drop, config returns to defaults,
// supervisor state clears to zero. Depends on mfs_pkg, mfs_cfg, mfs_core.
`default_nettype none
module motor_fault_supervisor_top
  import mfs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  // left_pulses[15:0], right_pulses[31:16], tilt_angle[48:32],
  // setpoint_is_zero[49], zero fill [55:50]
  input  wire logic [55:0]           in_tdata,
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  // spin_fault[0], tilt_fault[1], clear_position[2], zero fill [7:3]
  output      logic [7:0]            out_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg;
  item_t item_r;
  logic  s1_valid_r;
  logic  out_valid_r;
  res_t  res;
  res_t  res_r;
  logic  adv;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  mfs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  mfs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.left_pulses      <= in_tdata[15:0];
      item_r.right_pulses     <= in_tdata[31:16];
      item_r.tilt_angle       <= in_tdata[48:32];
      item_r.setpoint_is_zero <= in_tdata[49];
    end
    if (adv) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, res_r};

  // a clearing word never reports the fault still set
  a_clear_drops_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.clear_position && res_r.spin_fault))
    else $error("clear_position with spin_fault set");

  // an empty input stage always takes a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stage empty but not ready");

  // a word in the input stage with the result side free moves on
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("input stage word did not reach result register");

endmodule
`default_nettype wire

// ===== sv/mfs_cfg.sv =====
// mfs_cfg: configuration register file with reset defaults.
// Depends on mfs_pkg.
`default_nettype none
module mfs_cfg
  import mfs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_SPIN_SPEED_LIMIT:    cfg_nxt.spin_speed_limit    = wr_data[14:0];
        REG_SPIN_TICK_LIMIT:     cfg_nxt.spin_tick_limit     = wr_data;
        REG_TILT_LIMIT:          cfg_nxt.tilt_limit          = wr_data;
        REG_LEVEL_WINDOW:        cfg_nxt.level_window        = wr_data;
        REG_STILL_DELTA:         cfg_nxt.still_delta         = wr_data;
        REG_CHECK_INTERVAL:      cfg_nxt.check_interval      = wr_data;
        REG_STILL_CHECKS_NEEDED: cfg_nxt.still_checks_needed = wr_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spin_speed_limit    <= 15'd30;
      cfg_r.spin_tick_limit     <= 16'd50;
      cfg_r.tilt_limit          <= 16'd7680;
      cfg_r.level_window        <= 16'd1280;
      cfg_r.still_delta         <= 16'd205;
      cfg_r.check_interval      <= 16'd50;
      cfg_r.still_checks_needed <= 8'd4;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== sv/mfs_core.sv =====
// mfs_core: supervisor state (spin run, level ticks, still checks) and the
// per-tick next-state and result logic. Depends on mfs_pkg.
`default_nettype none
module mfs_core
  import mfs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output res_t       res
);

  logic [15:0]        spin_run_r, spin_run_nxt;
  logic               spin_flag_r, spin_flag_nxt;
  logic [15:0]        level_cnt_r, level_cnt_nxt;
  logic [7:0]         still_cnt_r, still_cnt_nxt;
  logic signed [16:0] last_angle_r, last_angle_nxt;

  logic signed [16:0] sl;
  logic signed [19:0] angle20;
  logic signed [19:0] delta20;
  logic               same_fast;
  logic               upright;
  logic               level;
  logic               still;
  logic [15:0]        run_inc;
  logic [15:0]        level_inc;
  logic [7:0]         still_inc;
  logic               clear;

  always_comb begin
    sl        = signed'({2'b00, cfg.spin_speed_limit});
    angle20   = 20'(item.tilt_angle);
    delta20   = 20'(item.tilt_angle) - 20'(last_angle_r);
    same_fast = (17'(item.left_pulses) > sl && 17'(item.right_pulses) > sl) ||
                (17'(item.left_pulses) < -sl && 17'(item.right_pulses) < -sl);
    upright   = within_f(angle20, {1'b0, cfg.tilt_limit});
    level     = within_f(angle20, {1'b0, cfg.level_window});
    still     = within_f(delta20, {1'b0, cfg.still_delta});
    run_inc   = spin_run_r + 16'd1;
    level_inc = level_cnt_r + 16'd1;
    still_inc = still_cnt_r + 8'd1;

    spin_run_nxt   = 16'd0;
    spin_flag_nxt  = spin_flag_r;
    level_cnt_nxt  = level_cnt_r;
    still_cnt_nxt  = still_cnt_r;
    last_angle_nxt = last_angle_r;
    clear          = 1'b0;

    // free-spin detection
    if (item.setpoint_is_zero && same_fast && upright) begin
      if (run_inc > cfg.spin_tick_limit) begin
        spin_flag_nxt = 1'b1;
      end else begin
        spin_run_nxt = run_inc;
      end
    end

    // landing detection sees a fault raised on this tick
    if (spin_flag_nxt) begin
      if (level) begin
        if (level_inc >= cfg.check_interval) begin
          level_cnt_nxt  = 16'd0;
          last_angle_nxt = item.tilt_angle;
          if (still) begin
            if (still_inc >= cfg.still_checks_needed) begin
              still_cnt_nxt = 8'd0;
              clear         = 1'b1;
              spin_flag_nxt = 1'b0;
            end else begin
              still_cnt_nxt = still_inc;
            end
          end else begin
            still_cnt_nxt = 8'd0;
          end
        end else begin
          level_cnt_nxt = level_inc;
        end
      end else begin
        level_cnt_nxt = 16'd0;
        still_cnt_nxt = 8'd0;
      end
    end

    res.spin_fault     = spin_flag_nxt;
    res.tilt_fault     = !within_f(angle20, 17'({1'b0, cfg.tilt_limit}) + 17'd1);
    res.clear_position = clear;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_run_r   <= '0;
      spin_flag_r  <= 1'b0;
      level_cnt_r  <= '0;
      still_cnt_r  <= '0;
      last_angle_r <= '0;
    end else if (step) begin
      spin_run_r   <= spin_run_nxt;
      spin_flag_r  <= spin_flag_nxt;
      level_cnt_r  <= level_cnt_nxt;
      still_cnt_r  <= still_cnt_nxt;
      last_angle_r <= last_angle_nxt;
    end
  end

endmodule
`default_nettype wire
